// ----- rtl/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// bba_pkg
// Shared widths, operation and status codes, and types of the block bitmap
// allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int unsigned MAX_BLOCKS = 4096;
  localparam int unsigned CNT_W      = $clog2(MAX_BLOCKS) + 1;
  localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned OPC_W      = 3;
  localparam int unsigned STS_W      = 2;

  // The map is held as 64-bit rows; block b is bit b[5:0] of row b[11:6].
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned POS_W      = $clog2(WORD_W);
  localparam int unsigned ROWS       = MAX_BLOCKS / WORD_W;
  localparam int unsigned ROW_W      = IDX_W - POS_W;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(MAX_BLOCKS);

  localparam logic [OPC_W-1:0] OP_QUERY = 3'd0;
  localparam logic [OPC_W-1:0] OP_MARK  = 3'd1;
  localparam logic [OPC_W-1:0] OP_FREE  = 3'd2;
  localparam logic [OPC_W-1:0] OP_FIND  = 3'd3;
  localparam logic [OPC_W-1:0] OP_ALLOC = 3'd4;

  localparam logic [STS_W-1:0] STS_OK      = 2'd0;
  localparam logic [STS_W-1:0] STS_RANGE   = 2'd1;
  localparam logic [STS_W-1:0] STS_NOSPACE = 2'd2;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] pos;
  } scan_res_t;

  // Packed so that status lands in the lowest bits.
  typedef struct packed {
    logic [IDX_W-1:0] found_index;
    logic             used_flag;
    logic [STS_W-1:0] status;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/bba_map_ram.sv -----
// ----------------------------------------------------------------------------
// bba_map_ram
// Bitmap store: one write port, one registered read port, and a valid bit per
// row so that a row never written reads as all free.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_map_ram
  import bba_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              we_i,
  input  wire logic [ROW_W-1:0]  waddr_i,
  input  wire logic [WORD_W-1:0] wdata_i,
  input  wire logic [ROW_W-1:0]  raddr_i,
  output logic      [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem_q [ROWS];
  logic [ROWS-1:0]   valid_q;
  logic [WORD_W-1:0] rdata_q;
  logic              rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= valid_q[raddr_i];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ----- rtl/bba_scan_unit.sv -----
// ----------------------------------------------------------------------------
// bba_scan_unit
// Finds the lowest free block of one map row, limited to the blocks below
// the effective block count.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_scan_unit
  import bba_pkg::*;
(
  input  wire logic [WORD_W-1:0] row_data_i,
  input  wire logic [ROW_W-1:0]  row_i,
  input  wire logic [CNT_W-1:0]  eff_count_i,
  output scan_res_t              res_o
);

  logic [CNT_W-POS_W-1:0] row_ext;
  logic [WORD_W-1:0]      limit;
  logic [WORD_W-1:0]      free_bits;

  assign row_ext = (CNT_W-POS_W)'(row_i);

  // Rows below the count's row are whole, the count's own row is partial.
  always_comb begin
    if (row_ext < eff_count_i[CNT_W-1:POS_W]) begin
      limit = '1;
    end else if (row_ext == eff_count_i[CNT_W-1:POS_W]) begin
      limit = (WORD_W'(1) << eff_count_i[POS_W-1:0]) - WORD_W'(1);
    end else begin
      limit = '0;
    end
  end

  assign free_bits = ~row_data_i & limit;

  always_comb begin
    res_o = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        res_o.found = 1'b1;
        res_o.pos   = POS_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/block_bitmap_allocator.sv -----
// Query, mark and free pass through the read and modify states to the result;
// find and allocate read and check the 64-bit map rows in turn, from 1 to 64
// of them. Out-of-range requests and unused opcodes go straight to the result.
// One item is in work at a time; the next input transfer can share the edge of
// the previous result transfer.
// Reset (rst_ni low, asynchronous) frees every block and sets the count to 4096.
// ----------------------------------------------------------------------------
// block_bitmap_allocator
// First-fit free block allocator over a used/free bitmap with query, mark,
// free, find and allocate operations.
// ----------------------------------------------------------------------------
`default_nettype none

module block_bitmap_allocator
  import bba_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration: block_count
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [12:0] cfg_data_i,
  // Input items
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [2:0] opcode, [14:3] block_index
  // Result items
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [15:0] m_axis_tdata_o    // [1:0] status, [2] used_flag,
                                             // [14:3] found_index
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_MODIFY = 5'b01000,
    S_RESP   = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  eff_count;
  logic [OPC_W-1:0]  op_q, op_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [ROW_W-1:0]  row_q, row_d;
  result_t           res_q, res_d;
  result_t           out_q;
  logic              out_valid_q;
  logic              load_out;

  logic [OPC_W-1:0]  in_op;
  logic [IDX_W-1:0]  in_idx;
  logic              s_fire;

  logic              mem_we;
  logic [WORD_W-1:0] mem_wdata;
  logic [ROW_W-1:0]  mem_raddr;
  logic [WORD_W-1:0] mem_rdata;
  logic [WORD_W-1:0] bit_sel;
  scan_res_t         scan;
  logic              last_row;
  logic              is_search;

  assign eff_count = (count_q > CNT_RESET) ? CNT_RESET : count_q;

  assign in_op  = s_axis_tdata_i[OPC_W-1:0];
  assign in_idx = s_axis_tdata_i[OPC_W+IDX_W-1:OPC_W];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i & s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  assign is_search = (op_q == OP_FIND) || (op_q == OP_ALLOC);

  // While scanning, the next row is read ahead so that one row is checked
  // every cycle.
  assign mem_raddr = (state_q == S_SCAN) ? row_q + ROW_W'(1) : row_q;

  bba_map_ram u_map_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (row_q),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bba_scan_unit u_scan_unit (
    .row_data_i  (mem_rdata),
    .row_i       (row_q),
    .eff_count_i (eff_count),
    .res_o       (scan)
  );

  assign last_row = (row_q == ROW_W'(ROWS - 1))
                 || ((CNT_W-POS_W)'(row_q) >= eff_count[CNT_W-1:POS_W]);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    idx_d     = idx_q;
    row_d     = row_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_wdata = mem_rdata;
    bit_sel   = WORD_W'(1) << idx_q[POS_W-1:0];
    load_out  = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          op_d  = in_op;
          idx_d = in_idx;
          res_d = '0;
          if (in_op == OP_QUERY || in_op == OP_MARK || in_op == OP_FREE) begin
            if ({1'b0, in_idx} >= eff_count) begin
              res_d.status = STS_RANGE;
              state_d      = S_RESP;
            end else begin
              row_d   = in_idx[IDX_W-1:POS_W];
              state_d = S_READ;
            end
          end else if (in_op == OP_FIND || in_op == OP_ALLOC) begin
            row_d   = '0;
            state_d = S_READ;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_READ: begin
        state_d = is_search ? S_SCAN : S_MODIFY;
      end
      S_MODIFY: begin
        if (op_q == OP_QUERY) begin
          res_d.used_flag = |(mem_rdata & bit_sel);
        end else begin
          mem_we    = 1'b1;
          mem_wdata = (op_q == OP_MARK) ? (mem_rdata | bit_sel) : (mem_rdata & ~bit_sel);
        end
        state_d = S_RESP;
      end
      S_SCAN: begin
        if (scan.found) begin
          res_d.found_index = {row_q, scan.pos};
          if (op_q == OP_ALLOC) begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata | (WORD_W'(1) << scan.pos);
          end
          state_d = S_RESP;
        end else if (last_row) begin
          res_d.status = STS_NOSPACE;
          state_d      = S_RESP;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end
      S_RESP: begin
        if (!out_valid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= CNT_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    idx_q <= idx_d;
    row_q <= row_d;
    res_q <= res_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_q};

`ifndef ASSERT_OFF
  // The input is not ready in the cycle after an accepted item.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready_o)
    else $error("input accepted back to back");

  // The map is only written while an item is in work.
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_MODIFY || state_q == S_SCAN))
    else $error("map written outside an operation");

  // No-space is reported only by the search operations.
  a_nospace_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_out && res_q.status == STS_NOSPACE) |-> is_search)
    else $error("no-space status on a non-search operation");

  // A found block always lies below the effective count.
  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && scan.found)
      |-> ({1'b0, row_q, scan.pos} < eff_count))
    else $error("search found a block beyond the count");
`endif

endmodule

`default_nettype wire

// ----- tb/bba_alloc_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bba_alloc_checker
// Watches the configuration, request and result channels of the block bitmap
// allocator. It keeps its own copy of the used/free map and the block count,
// works out the result of every accepted request, and compares each result
// transfer, field by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module bba_alloc_checker
  import bba_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [12:0] cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,   // [2:0] opcode, [14:3] block_index
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,   // [1:0] status, [2] used_flag, [14:3] found_index
  output int          pending_o,
  output int          errors_o
);

  logic [MAX_BLOCKS-1:0] used_map;
  logic [CNT_W-1:0]      block_count;
  result_t               awaited_results[$];

  // Applies one request to the map copy and returns the result it yields.
  task automatic predict_bitmap_op(input logic [OPC_W-1:0] op,
                                   input logic [IDX_W-1:0] idx,
                                   output result_t res);
    int unsigned lim;
    logic        hit;
    lim = (block_count > MAX_BLOCKS) ? MAX_BLOCKS : block_count;
    res = '0;
    hit = 1'b0;
    case (op)
      OP_QUERY, OP_MARK, OP_FREE: begin
        if (idx >= lim) begin
          res.status = STS_RANGE;
        end else if (op == OP_QUERY) begin
          res.used_flag = used_map[idx];
        end else begin
          used_map[idx] = (op == OP_MARK);
        end
      end
      OP_FIND, OP_ALLOC: begin
        for (int unsigned b = 0; b < lim && !hit; b++) begin
          if (!used_map[b]) begin
            hit = 1'b1;
            res.found_index = IDX_W'(b);
          end
        end
        if (!hit) begin
          res.status = STS_NOSPACE;
        end else if (op == OP_ALLOC) begin
          used_map[res.found_index] = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      used_map = '0;
      block_count = CNT_RESET;
      awaited_results.delete();
      pending_o = 0;
      errors_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        block_count = cfg_data_i;
      end
      if (s_tvalid_i && s_tready_i) begin
        predict_bitmap_op(s_tdata_i[OPC_W-1:0], s_tdata_i[OPC_W +: IDX_W], want);
        awaited_results.push_back(want);
      end
      if (m_tvalid_i && m_tready_i) begin
        got = result_t'(m_tdata_i[$bits(result_t)-1:0]);
        if (awaited_results.size() == 0) begin
          if (errors_o < 10) begin
            $display("%0t: unexpected result: status %0d used %0d found %0d",
                     $realtime, got.status, got.used_flag, got.found_index);
          end
          errors_o++;
        end else begin
          want = awaited_results.pop_front();
          if (got.status !== want.status || got.used_flag !== want.used_flag ||
              got.found_index !== want.found_index) begin
            if (errors_o < 10) begin
              $display("%0t: mismatch: want sts %0d used %0d found %0d, got %0d %0d %0d",
                       $realtime, want.status, want.used_flag, want.found_index,
                       got.status, got.used_flag, got.found_index);
            end
            errors_o++;
          end
        end
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

// ----- tb/tb_block_bitmap_allocator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_block_bitmap_allocator
// Drives query, mark, free, find and allocate requests into the block bitmap
// allocator under a range of block counts, with random gaps on both streams
// and one long result stall, and reports the verdict of the checker.
// ----------------------------------------------------------------------------

module tb_block_bitmap_allocator
  import bba_pkg::*;
;

  localparam logic [OPC_W-1:0] OP_SPARE_FIRST = OP_ALLOC + 1;
  localparam logic [OPC_W-1:0] OP_SPARE_LAST  = '1;
  localparam int               LONG_HOLD      = 300;
  localparam int               SETTLE_CYCLES  = 80;
  localparam int               PHASES         = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [12:0] cfg_data;
  logic        s_valid;
  logic        s_ready;
  logic [15:0] s_data;
  logic        m_valid;
  logic        m_ready;
  logic [15:0] m_data;
  int          pending;
  int          errors;

  logic        no_gaps;
  logic        hold_request;
  int unsigned cur_count;

  // Block count, fill allocations and mixed requests of each random phase.
  int unsigned phase_count[PHASES] = '{8, 64, 100, 13, 200, 4096, 8191, 0, 4095, 512};
  int          phase_fill[PHASES]  = '{12, 0, 110, 0, 210, 0, 0, 0, 0, 0};
  int          phase_mixed[PHASES] = '{40, 150, 60, 60, 0, 150, 100, 20, 60, 40};

  block_bitmap_allocator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  bba_alloc_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_valid),
    .s_tready_i  (s_ready),
    .s_tdata_i   (s_data),
    .m_tvalid_i  (m_valid),
    .m_tready_i  (m_ready),
    .m_tdata_i   (m_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: a random stall before each transfer, or a long one on request.
  initial begin
    int   gap;
    logic hold_done;
    m_ready   = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request && !hold_done) begin
        gap       = LONG_HOLD;
        hold_done = 1'b1;
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 10);
      end
      if (gap > 0) begin
        m_ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_valid);
    end
  end

  task automatic send_request(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] idx);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_data  <= {1'b0, idx, op};
    s_valid <= 1'b1;
    do @(posedge clk_i); while (!s_ready);
  endtask

  // Lets every outstanding result arrive before the count changes.
  task automatic drain_results();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_count(input int unsigned value);
    drain_results();
    cfg_data  <= 13'(value);
    cfg_valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    cur_count = value;
  endtask

  // Mostly in-range addresses and allocations, with some stray indices and
  // unused opcodes mixed in.
  task automatic send_mixed();
    int unsigned lim;
    int          pick;
    logic [OPC_W-1:0] op;
    logic [IDX_W-1:0] idx;
    lim  = (cur_count > MAX_BLOCKS) ? MAX_BLOCKS : cur_count;
    pick = $urandom_range(0, 99);
    if (pick < 20)      op = OP_QUERY;
    else if (pick < 38) op = OP_MARK;
    else if (pick < 58) op = OP_FREE;
    else if (pick < 70) op = OP_FIND;
    else if (pick < 94) op = OP_ALLOC;
    else                op = OPC_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    if (lim > 0 && $urandom_range(0, 99) < 85) idx = IDX_W'($urandom_range(0, lim - 1));
    else                                       idx = IDX_W'($urandom);
    send_request(op, idx);
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    s_valid      = 1'b0;
    s_data       = '0;
    no_gaps      = 1'b0;
    hold_request = 1'b0;
    cur_count    = MAX_BLOCKS;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Full block count after reset: both ends of the index range and first-fit order.
    send_request(OP_QUERY, '0);
    send_request(OP_QUERY, '1);
    send_request(OP_MARK, '0);
    send_request(OP_MARK, '1);
    send_request(OP_QUERY, '1);
    send_request(OP_FIND, '1);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '1);
    send_request(OP_FREE, '1);
    send_request(OP_FREE, '0);
    send_request(OP_FIND, '0);
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
      send_request(OPC_W'(op), '1);
    end

    // A zero count puts every index out of range and leaves nothing to find.
    write_count(0);
    send_request(OP_QUERY, '0);
    send_request(OP_MARK, '1);
    send_request(OP_FIND, '0);
    send_request(OP_ALLOC, '0);

    // A count above capacity saturates at the map size.
    write_count(8191);
    send_request(OP_QUERY, '1);
    send_request(OP_FREE, IDX_W'(2048));

    // A count that is not a multiple of eight bounds the index exactly.
    write_count(13);
    send_request(OP_MARK, IDX_W'(13));
    send_request(OP_MARK, IDX_W'(12));
    send_request(OP_QUERY, IDX_W'(12));

    for (int p = 0; p < PHASES; p++) begin
      write_count(phase_count[p]);
      no_gaps = (p == 4);
      if (phase_count[p] == MAX_BLOCKS) hold_request = 1'b1;
      for (int i = 0; i < phase_fill[p]; i++) begin
        send_request(OP_ALLOC, IDX_W'($urandom));
      end
      for (int i = 0; i < phase_mixed[p]; i++) begin
        send_mixed();
      end
    end
    no_gaps = 1'b0;

    drain_results();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- block_bitmap_allocator.f -----
rtl/bba_pkg.sv
rtl/bba_map_ram.sv
rtl/bba_scan_unit.sv
rtl/block_bitmap_allocator.sv
tb/bba_alloc_checker.sv
tb/tb_block_bitmap_allocator.sv
